### rtl/nsl_pkg.sv
// Package for the nearest-site pixel labeler.
// Widths, command and register codes, and the token that walks the cell chain.
// No dependencies.
package nsl_pkg;

    localparam int MAX_SITES = 256;
    localparam int FRAC_BITS = 8;
    localparam int COORD_BITS = 12;

    localparam int POS_W = COORD_BITS + FRAC_BITS;
    localparam int PIX_W = COORD_BITS;
    localparam int COLOR_W = 24;
    localparam int SQ_W = 2 * POS_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int IDX_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W = $clog2(MAX_SITES + 1);
    localparam int NEAR_W = 8;
    localparam int DIM_W = 13;
    localparam int RAD_W = 3;
    localparam int R2_W = 2 * RAD_W;
    localparam int CMD_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MCOLOR = 2'd3;

    // query token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic               outside;
        logic               empty;
        logic               have;
        logic [DIST_W-1:0]  d2;
        logic [IDX_W-1:0]   idx;
        logic [COLOR_W-1:0] color;
        logic               marker;
    } t_tok;

    // site write broadcast to all cells
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } t_site_wr;

endpackage

### rtl/nsl_cell.sv
// One site cell of the labeler chain: holds one site and updates the passing token.
// Two register stages: squares and marker test, then sum and compare.
// Depends on nsl_pkg.
module nsl_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [nsl_pkg::IDX_W-1:0]  i_index,
    input  logic [nsl_pkg::CNT_W-1:0]  i_count,
    input  logic [nsl_pkg::R2_W-1:0]   i_r2,
    input  logic                       i_stall,
    input  nsl_pkg::t_site_wr          i_wr,
    input  nsl_pkg::t_tok              i_tok,
    output nsl_pkg::t_tok              o_tok
);

    logic [nsl_pkg::POS_W-1:0]   r_sx;
    logic [nsl_pkg::POS_W-1:0]   r_sy;
    logic [nsl_pkg::COLOR_W-1:0] r_scolor;

    nsl_pkg::t_tok               r_a;
    nsl_pkg::t_tok               r_b;
    nsl_pkg::t_tok               n_b;
    logic [nsl_pkg::SQ_W-1:0]    r_sqx;
    logic [nsl_pkg::SQ_W-1:0]    r_sqy;
    logic                        r_use;
    logic                        r_mhit;

    logic [nsl_pkg::POS_W-1:0]   w_fx;
    logic [nsl_pkg::POS_W-1:0]   w_fy;
    logic [nsl_pkg::POS_W-1:0]   w_dx;
    logic [nsl_pkg::POS_W-1:0]   w_dy;
    logic [nsl_pkg::PIX_W-1:0]   w_ix;
    logic [nsl_pkg::PIX_W-1:0]   w_iy;
    logic [nsl_pkg::PIX_W-1:0]   w_mx;
    logic [nsl_pkg::PIX_W-1:0]   w_my;
    logic [nsl_pkg::R2_W:0]      w_m2;
    logic                        w_use;
    logic                        w_mhit;
    logic [nsl_pkg::DIST_W-1:0]  w_d;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_sx     <= i_wr.x;
            r_sy     <= i_wr.y;
            r_scolor <= i_wr.color;
        end
    end

    // stage A
    always_comb begin
        w_fx = {i_tok.px, {nsl_pkg::FRAC_BITS{1'b0}}};
        w_fy = {i_tok.py, {nsl_pkg::FRAC_BITS{1'b0}}};
        w_dx = (r_sx >= w_fx) ? (r_sx - w_fx) : (w_fx - r_sx);
        w_dy = (r_sy >= w_fy) ? (r_sy - w_fy) : (w_fy - r_sy);
        w_ix = r_sx[nsl_pkg::POS_W-1:nsl_pkg::FRAC_BITS];
        w_iy = r_sy[nsl_pkg::POS_W-1:nsl_pkg::FRAC_BITS];
        w_mx = (w_ix >= i_tok.px) ? (w_ix - i_tok.px) : (i_tok.px - w_ix);
        w_my = (w_iy >= i_tok.py) ? (w_iy - i_tok.py) : (i_tok.py - w_iy);
        w_m2 = (nsl_pkg::R2_W+1)'(w_mx[2:0]) * (nsl_pkg::R2_W+1)'(w_mx[2:0])
             + (nsl_pkg::R2_W+1)'(w_my[2:0]) * (nsl_pkg::R2_W+1)'(w_my[2:0]);
        w_use = i_tok.valid && !i_tok.outside && !i_tok.empty
             && (nsl_pkg::CNT_W'(i_index) < i_count);
        w_mhit = (w_mx <= nsl_pkg::PIX_W'(7)) && (w_my <= nsl_pkg::PIX_W'(7))
              && (w_m2 <= {1'b0, i_r2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (!i_stall) begin
            r_a    <= i_tok;
            r_sqx  <= w_dx * w_dx;
            r_sqy  <= w_dy * w_dy;
            r_use  <= w_use;
            r_mhit <= w_mhit;
        end
    end

    // stage B
    always_comb begin
        w_d = {1'b0, r_sqx} + {1'b0, r_sqy};
        n_b = r_a;
        if (r_use) begin
            if (!r_a.have || (w_d < r_a.d2)) begin
                n_b.have  = 1'b1;
                n_b.d2    = w_d;
                n_b.idx   = i_index;
                n_b.color = r_scolor;
            end
            n_b.marker = r_a.marker | r_mhit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (!i_stall) begin
            r_b <= n_b;
        end
    end

    assign o_tok = r_b;

endmodule

### rtl/nearest_site_pixel_labeler.sv
// Top level of the nearest-site pixel labeler: command decode, site count,
// configuration registers, the chain of site cells and the result register.
// Depends on nsl_pkg and nsl_cell.

// Clear and load transactions give no result. A query walks the chain of
// MAX_SITES cells, two register stages per cell, before its result is registered;
// one query is in flight at a time and the input is held off until its result
// has entered the output register. A waiting result does not block clear or load.
module nearest_site_pixel_labeler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nsl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [nsl_pkg::CMD_W-1:0]       i_cmd,
    input  logic [nsl_pkg::POS_W-1:0]       i_site_x,
    input  logic [nsl_pkg::POS_W-1:0]       i_site_y,
    input  logic [nsl_pkg::COLOR_W-1:0]     i_site_color,
    input  logic [nsl_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [nsl_pkg::PIX_W-1:0]       i_pixel_y,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [nsl_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic [nsl_pkg::NEAR_W-1:0]      o_nearest_index,
    output logic                            o_is_marker,
    output logic                            o_no_sites,
    output logic                            o_out_of_image
);

    logic [nsl_pkg::DIM_W-1:0]      r_width;
    logic [nsl_pkg::DIM_W-1:0]      r_height;
    logic [nsl_pkg::RAD_W-1:0]      r_radius;
    logic [nsl_pkg::COLOR_W-1:0]    r_mcolor;
    logic [nsl_pkg::CNT_W-1:0]      r_count;
    logic                           r_busy;
    logic [nsl_pkg::R2_W-1:0]       w_r2;

    logic                           r_ovalid;
    logic [nsl_pkg::COLOR_W-1:0]    r_color;
    logic [nsl_pkg::NEAR_W-1:0]     r_idx;
    logic                           r_marker;
    logic                           r_empty;
    logic                           r_outside;

    logic                           w_acc;
    logic                           w_stall;
    logic                           w_done;
    logic                           w_flag;
    nsl_pkg::t_site_wr              w_wr;
    nsl_pkg::t_tok                  w_tok [nsl_pkg::MAX_SITES+1];
    nsl_pkg::t_tok                  w_last;

    assign o_ready = !r_busy;
    assign w_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= nsl_pkg::DIM_W'(4096);
            r_height <= nsl_pkg::DIM_W'(4096);
            r_radius <= nsl_pkg::RAD_W'(2);
            r_mcolor <= nsl_pkg::COLOR_W'(24'hFFFFFF);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nsl_pkg::REG_WIDTH:  r_width  <= i_cfg_data[nsl_pkg::DIM_W-1:0];
                nsl_pkg::REG_HEIGHT: r_height <= i_cfg_data[nsl_pkg::DIM_W-1:0];
                nsl_pkg::REG_RADIUS: r_radius <= i_cfg_data[nsl_pkg::RAD_W-1:0];
                nsl_pkg::REG_MCOLOR: r_mcolor <= i_cfg_data[nsl_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_r2 = nsl_pkg::R2_W'(r_radius) * nsl_pkg::R2_W'(r_radius);

    always_comb begin
        w_wr.en    = w_acc && (i_cmd == nsl_pkg::CMD_LOAD)
                  && (r_count < nsl_pkg::CNT_W'(nsl_pkg::MAX_SITES));
        w_wr.idx   = r_count[nsl_pkg::IDX_W-1:0];
        w_wr.x     = i_site_x;
        w_wr.y     = i_site_y;
        w_wr.color = i_site_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc && (i_cmd == nsl_pkg::CMD_CLEAR)) begin
            r_count <= '0;
        end else if (w_wr.en) begin
            r_count <= r_count + nsl_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        w_tok[0]         = '0;
        w_tok[0].valid   = w_acc && (i_cmd == nsl_pkg::CMD_QUERY);
        w_tok[0].px      = i_pixel_x;
        w_tok[0].py      = i_pixel_y;
        w_tok[0].outside = ({1'b0, i_pixel_x} >= r_width)
                        || ({1'b0, i_pixel_y} >= r_height);
        w_tok[0].empty   = (r_count == '0);
    end

    assign w_last  = w_tok[nsl_pkg::MAX_SITES];
    assign w_stall = w_last.valid && r_ovalid && !i_ready;
    assign w_done  = w_last.valid && !w_stall;

    for (genvar g = 0; g < nsl_pkg::MAX_SITES; g++) begin : g_cell
        nsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (nsl_pkg::IDX_W'(g)),
            .i_count (r_count),
            .i_r2    (w_r2),
            .i_stall (w_stall),
            .i_wr    (w_wr),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_acc && (i_cmd == nsl_pkg::CMD_QUERY)) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    assign w_flag = w_last.outside || w_last.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_done) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_color   <= w_flag ? '0 : (w_last.marker ? r_mcolor : w_last.color);
            r_idx     <= w_flag ? '0 : nsl_pkg::NEAR_W'(w_last.idx);
            r_marker  <= !w_flag && w_last.marker;
            r_empty   <= w_last.empty;
            r_outside <= w_last.outside;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_pixel_color   = r_color;
    assign o_nearest_index = r_idx;
    assign o_is_marker     = r_marker;
    assign o_no_sites      = r_empty;
    assign o_out_of_image  = r_outside;

endmodule

### sim/tb_nearest_site_pixel_labeler.sv
// Self-checking testbench for nearest_site_pixel_labeler: directed and random
// clear/load/query transactions, with a predictor that checks every pixel label.
// Depends on nsl_pkg and the labeler RTL.
`timescale 1ns / 1ps

module tb_nearest_site_pixel_labeler;

    localparam int MAX_SITES = nsl_pkg::MAX_SITES;
    localparam int FRAC_BITS = nsl_pkg::FRAC_BITS;
    localparam int POS_W = nsl_pkg::POS_W;
    localparam int PIX_W = nsl_pkg::PIX_W;
    localparam int COLOR_W = nsl_pkg::COLOR_W;
    localparam int NEAR_W = nsl_pkg::NEAR_W;
    localparam int DIM_W = nsl_pkg::DIM_W;
    localparam int RAD_W = nsl_pkg::RAD_W;
    localparam int CMD_W = nsl_pkg::CMD_W;
    localparam int CFG_IDX_W = nsl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = nsl_pkg::CFG_DATA_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PIX_MAX = (1 << PIX_W) - 1;
    localparam int DRAIN_CYCLES = 2 * MAX_SITES + 8;
    localparam int HOLD_CYCLES = 4 * (2 * MAX_SITES + 1);
    localparam longint LIMIT_NS = 64'd20_000_000;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [NEAR_W-1:0]  near_idx;
        logic               marker;
        logic               empty;
        logic               outside;
    } t_label;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [CMD_W-1:0]      i_cmd;
    logic [POS_W-1:0]      i_site_x;
    logic [POS_W-1:0]      i_site_y;
    logic [COLOR_W-1:0]    i_site_color;
    logic [PIX_W-1:0]      i_pixel_x;
    logic [PIX_W-1:0]      i_pixel_y;
    logic                  o_valid;
    logic                  i_ready;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic [NEAR_W-1:0]     o_nearest_index;
    logic                  o_is_marker;
    logic                  o_no_sites;
    logic                  o_out_of_image;

    nearest_site_pixel_labeler dut (.*);

    // predictor state
    logic [POS_W-1:0]   site_pos_x [MAX_SITES];
    logic [POS_W-1:0]   site_pos_y [MAX_SITES];
    logic [COLOR_W-1:0] site_rgb [MAX_SITES];
    int                 site_total = 0;
    logic [DIM_W-1:0]   cfg_width = 13'd4096;
    logic [DIM_W-1:0]   cfg_height = 13'd4096;
    logic [RAD_W-1:0]   disc_radius = 3'd2;
    logic [COLOR_W-1:0] disc_color = 24'hFFFFFF;
    t_label             label_queue [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  configs_used = 1;
    int  n_labels = 0;
    int  n_marker = 0;
    int  n_outside = 0;
    int  n_empty = 0;
    bit  no_idle = 1'b0;
    bit  hold_req = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #LIMIT_NS;
        $display("timeout at %0t with %0d labels outstanding", $time, label_queue.size());
        $display("tb_nearest_site_pixel_labeler failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint unsigned span_between(longint unsigned a, longint unsigned b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [PIX_W-1:0] to_pixel(int c);
        if (c < 0) c = 0;
        if (c > PIX_MAX) c = PIX_MAX;
        return c[PIX_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] near_coord(logic [POS_W-1:0] pos, int reach);
        return to_pixel(int'(pos >> FRAC_BITS) + int'($urandom_range(0, 2 * reach)) - reach);
    endfunction

    function automatic logic [POS_W-1:0] window_pos(int origin, int win);
        return POS_W'(origin << FRAC_BITS) + POS_W'($urandom_range(0, (win << FRAC_BITS) - 1));
    endfunction

    // updates the site table and queues the label a query should produce
    task automatic apply_transaction(input logic [CMD_W-1:0] cmd,
                                     input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                                     input logic [COLOR_W-1:0] sc,
                                     input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        t_label lab;
        longint unsigned fx, fy, dx, dy, sq_span, best_span;
        int best, mx, my, r2;
        lab = '0;
        case (cmd)
            nsl_pkg::CMD_CLEAR: begin
                site_total = 0;
            end
            nsl_pkg::CMD_LOAD: begin
                if (site_total < MAX_SITES) begin
                    site_pos_x[site_total] = sx;
                    site_pos_y[site_total] = sy;
                    site_rgb[site_total] = sc;
                    site_total++;
                end
            end
            nsl_pkg::CMD_QUERY: begin
                lab.empty = (site_total == 0);
                lab.outside = (px >= cfg_width) || (py >= cfg_height);
                if (!lab.empty && !lab.outside) begin
                    fx = 64'(px) << FRAC_BITS;
                    fy = 64'(py) << FRAC_BITS;
                    r2 = int'(disc_radius) * int'(disc_radius);
                    best = 0;
                    best_span = 0;
                    for (int i = 0; i < site_total; i++) begin
                        dx = span_between(site_pos_x[i], fx);
                        dy = span_between(site_pos_y[i], fy);
                        sq_span = dx * dx + dy * dy;
                        if (i == 0 || sq_span < best_span) begin
                            best_span = sq_span;
                            best = i;
                        end
                        mx = int'(span_between(site_pos_x[i] >> FRAC_BITS, px));
                        my = int'(span_between(site_pos_y[i] >> FRAC_BITS, py));
                        if (mx * mx + my * my <= r2) lab.marker = 1'b1;
                    end
                    lab.near_idx = best[NEAR_W-1:0];
                    lab.color = lab.marker ? disc_color : site_rgb[best];
                end
                label_queue.insert(label_queue.size(), lab);
            end
            default: ;
        endcase
        items_sent++;
    endtask

    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                             input logic [COLOR_W-1:0] sc,
                             input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd = cmd;
        i_site_x = sx;
        i_site_y = sy;
        i_site_color = sc;
        i_pixel_x = px;
        i_pixel_y = py;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        apply_transaction(cmd, sx, sy, sc, px, py);
    endtask

    task automatic query(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        send_item(nsl_pkg::CMD_QUERY, POS_W'($urandom()), POS_W'($urandom()),
                  COLOR_W'($urandom()), px, py);
    endtask

    task automatic load(input logic [POS_W-1:0] sx, input logic [POS_W-1:0] sy,
                        input logic [COLOR_W-1:0] sc);
        send_item(nsl_pkg::CMD_LOAD, sx, sy, sc, PIX_W'($urandom()), PIX_W'($urandom()));
    endtask

    task automatic clear_table();
        send_item(nsl_pkg::CMD_CLEAR, POS_W'($urandom()), POS_W'($urandom()),
                  COLOR_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()));
    endtask

    task automatic send_noise();
        send_item(CMD_UNUSED, POS_W'($urandom()), POS_W'($urandom()), COLOR_W'($urandom()),
                  PIX_W'($urandom()), PIX_W'($urandom()));
    endtask

    // query mix: near a stored site, inside the site window, at the image edge, anywhere
    task automatic aimed_query(input int origin_x, input int origin_y, input int win);
        int r, j, reach;
        r = $urandom_range(0, 99);
        reach = int'(disc_radius) + 1;
        if (site_total > 0 && r < 50) begin
            j = $urandom_range(0, site_total - 1);
            query(near_coord(site_pos_x[j], reach), near_coord(site_pos_y[j], reach));
        end else if (r < 75) begin
            query(to_pixel(origin_x + int'($urandom_range(0, win - 1))),
                  to_pixel(origin_y + int'($urandom_range(0, win - 1))));
        end else if (r < 88) begin
            query(to_pixel(int'(cfg_width) - 1 + int'($urandom_range(0, 1))),
                  to_pixel(int'(cfg_height) - 1 + int'($urandom_range(0, 1))));
        end else begin
            query(PIX_W'($urandom()), PIX_W'($urandom()));
        end
    endtask

    // block idle: all labels back and the chain flushed
    task automatic settle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (label_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            nsl_pkg::REG_WIDTH:  cfg_width = data[DIM_W-1:0];
            nsl_pkg::REG_HEIGHT: cfg_height = data[DIM_W-1:0];
            nsl_pkg::REG_RADIUS: disc_radius = data[RAD_W-1:0];
            nsl_pkg::REG_MCOLOR: disc_color = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [RAD_W-1:0] r, input logic [COLOR_W-1:0] c);
        settle();
        write_reg(nsl_pkg::REG_WIDTH, CFG_DATA_W'(w));
        write_reg(nsl_pkg::REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(nsl_pkg::REG_RADIUS, CFG_DATA_W'(r));
        write_reg(nsl_pkg::REG_MCOLOR, c);
        configs_used++;
    endtask

    task automatic test_empty_table();
        query(12'd0, 12'd0);
        query(12'hFFF, 12'hFFF);
        send_noise();
        clear_table();
        query(12'd7, 12'd9);
    endtask

    task automatic test_corner_sites();
        load(20'h00000, 20'h00000, 24'h000000);
        load(20'hFFFFF, 20'hFFFFF, 24'hA5C3F0);
        load(20'h80080, 20'h7FF7F, 24'h5A3C0F);
        query(12'd0, 12'd0);
        query(12'hFFF, 12'hFFF);
        query(12'd2, 12'd0);
        query(12'd2, 12'd1);
        send_noise();
        query(12'd2048, 12'd2047);
        query(12'd2051, 12'd2047);
    endtask

    task automatic test_ties();
        clear_table();
        load(20'd100 << FRAC_BITS, 20'd50 << FRAC_BITS, 24'h111111);
        load(20'd110 << FRAC_BITS, 20'd50 << FRAC_BITS, 24'h222222);
        load(20'd110 << FRAC_BITS, 20'd50 << FRAC_BITS, 24'h333333);
        query(12'd105, 12'd50);
        query(12'd107, 12'd50);
        query(12'd105, 12'd53);
    endtask

    task automatic test_image_bounds();
        set_config(13'd0, 13'd4096, 3'd2, 24'hFFFFFF);
        query(12'd0, 12'd0);
        set_config(13'd4096, 13'd51, 3'd0, 24'h000000);
        query(12'd100, 12'd50);
        query(12'd100, 12'd51);
        set_config(13'd1, 13'd4096, 3'd7, 24'h00FF00);
        query(12'd0, 12'd50);
        query(12'd1, 12'd50);
        clear_table();
        query(12'hFFF, 12'hFFF);
    endtask

    task automatic test_full_table();
        int ox, oy, j;
        set_config(13'd4096, 13'd4096, 3'd7, COLOR_W'($urandom()));
        ox = $urandom_range(0, 4096 - 64);
        oy = $urandom_range(0, 4096 - 64);
        clear_table();
        repeat (MAX_SITES) load(window_pos(ox, 64), window_pos(oy, 64), COLOR_W'($urandom()));
        // these land on a full table and must be dropped
        repeat (3) load(window_pos(ox, 64), window_pos(oy, 64), COLOR_W'($urandom()));
        query(i_pixel_x, i_pixel_y);
        query(near_coord(site_pos_x[0], 0), near_coord(site_pos_y[0], 0));
        query(near_coord(site_pos_x[MAX_SITES-1], 0), near_coord(site_pos_y[MAX_SITES-1], 0));
        for (j = 0; j < 14; j++) aimed_query(ox, oy, 64);
    endtask

    task automatic test_back_pressure();
        settle();
        no_idle = 1'b1;
        hold_req = 1'b1;
        query(PIX_W'($urandom()), PIX_W'($urandom()));
        query(PIX_W'($urandom()), PIX_W'($urandom()));
        clear_table();
        load(POS_W'($urandom()), POS_W'($urandom()), COLOR_W'($urandom()));
        load(POS_W'($urandom()), POS_W'($urandom()), COLOR_W'($urandom()));
        repeat (3) query(PIX_W'($urandom()), PIX_W'($urandom()));
        no_idle = 1'b0;
    endtask

    task automatic test_random(input int n_items);
        int ox, oy, win, lim, r, start_count;
        lim = (cfg_width > 13'd4096) ? 4096 : int'(cfg_width);
        win = $urandom_range(8, 128);
        ox = (lim > win) ? $urandom_range(0, lim - win) : 0;
        lim = (cfg_height > 13'd4096) ? 4096 : int'(cfg_height);
        oy = (lim > win) ? $urandom_range(0, lim - win) : 0;
        start_count = items_sent;
        clear_table();
        repeat ($urandom_range(2, 10)) load(window_pos(ox, win), window_pos(oy, win),
                                           COLOR_W'($urandom()));
        while (items_sent - start_count < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 5) clear_table();
            else if (r < 10) send_noise();
            else if (r < 35) load(window_pos(ox, win), window_pos(oy, win), COLOR_W'($urandom()));
            else if (r < 45) load(POS_W'($urandom()), POS_W'($urandom()), COLOR_W'($urandom()));
            else aimed_query(ox, oy, win);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_label want;
        if (i_rst_n && o_valid && i_ready) begin
            if (label_queue.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected label, expected none, actual color %h index %0d",
                         $time, o_pixel_color, o_nearest_index);
            end else begin
                want = label_queue.pop_front();
                check_field("pixel_color", want.color, o_pixel_color);
                check_field("nearest_index", want.near_idx, o_nearest_index);
                check_field("is_marker", want.marker, o_is_marker);
                check_field("no_sites", want.empty, o_no_sites);
                check_field("out_of_image", want.outside, o_out_of_image);
                n_labels++;
                n_marker += want.marker;
                n_outside += want.outside;
                n_empty += want.empty;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            n = pick_gap();
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready = 1'b0;
                n = HOLD_CYCLES;
            end else if (n > 0) begin
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
                n = 1;
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_cmd = nsl_pkg::CMD_CLEAR;
        i_site_x = '0;
        i_site_y = '0;
        i_site_color = '0;
        i_pixel_x = '0;
        i_pixel_y = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_corner_sites();
        test_ties();
        test_image_bounds();
        test_full_table();
        test_back_pressure();
        set_config(13'd4096, 13'd4096, 3'd7, 24'h000000);
        test_random(75);
        set_config(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 3'd0, 24'hFFFFFF);
        test_random(75);
        no_idle = 1'b1;
        set_config(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)),
                   3'($urandom_range(0, 7)), COLOR_W'($urandom()));
        test_random(75);
        no_idle = 1'b0;
        set_config(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   3'($urandom_range(0, 7)), COLOR_W'($urandom()));
        test_random(75);
        settle();

        $display("%0d transactions over %0d register settings; %0d labels checked",
                 items_sent, configs_used, n_labels);
        $display("labels with marker %0d, outside image %0d, empty table %0d; %0d mismatches",
                 n_marker, n_outside, n_empty, mismatches);
        if (mismatches == 0) begin
            $display("tb_nearest_site_pixel_labeler passed");
        end else begin
            $display("tb_nearest_site_pixel_labeler failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/nsl_pkg.sv
rtl/nsl_cell.sv
rtl/nearest_site_pixel_labeler.sv
sim/tb_nearest_site_pixel_labeler.sv
